// ----- src/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// rpn_pkg: shared constants and types for the RPN stack calculator
// Holds the stack geometry, character codes, status codes and the structs
// that connect the sequencer to the stack memory and the divider.
// ----------------------------------------------------------------------------
package rpn_pkg;

	// Stack geometry.
	localparam int DEPTH      = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int DATA_W     = 32;
	localparam int DIV_STEP_W = $clog2(DATA_W);

	// Character codes.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQUAL = 8'h3D;

	// Status codes.
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_INVALID   = 3'd1;
	localparam logic [2:0] STAT_UNDERFLOW = 3'd2;
	localparam logic [2:0] STAT_OVERFLOW  = 3'd3;
	localparam logic [2:0] STAT_DIVZERO   = 3'd4;

	// Stack memory access: one write and one read port.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// Divider request and response.
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- src/rpn_stack_calculator_core.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core: reverse Polish notation calculator
// Takes one character per beat and returns one status beat per character.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ---------------------------------
// in       to core    in_valid / in_stall  char_code
// out      from core  out_valid/out_stall  status, top_value, depth, done_res
//
// Sequence: a digit, '=', an invalid character or a rejected operator is
// accepted and finished in decode. '+', '-' and '*' pass through accept,
// decode, stack read and write back. '/' passes through accept, decode,
// stack read with divider start, the divider's steps of one quotient bit
// each, quotient capture and write back.
// Reset: arst_n clears the sequencer, the entry count and the output valid;
// the stack memory is not cleared, since only entries below the count are
// ever read. Stalls: the input beat is taken whenever the sequencer is idle,
// even while a result waits on the output; the sequencer then holds in
// place until the output register is free.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core
	import rpn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] top_value,
	output logic [5:0]         depth,
	output logic               done_res
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_READ_A   = 3'd2;
	localparam logic [2:0] S_DIV_WAIT = 3'd3;
	localparam logic [2:0] S_WRITE    = 3'd4;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	logic [2:0]        state_q;
	logic [7:0]        char_q;
	logic [CNT_W-1:0]  count_q;
	// Copy of the top entry of the stack; valid whenever count_q is nonzero.
	// It serves as operand b and forwards the newest write without a read.
	logic [DATA_W-1:0] top_q;
	logic [DATA_W-1:0] res_q;

	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [DATA_W-1:0] top_value_q;
	logic [5:0]        depth_q;
	logic              done_res_q;

	ram_req_t          ram_req;
	logic [DATA_W-1:0] ram_rd;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic              out_free;
	logic              out_load;
	logic              is_digit;
	logic              is_op;
	logic              is_div;
	logic              is_eq;
	logic              full;
	logic              has_two;
	logic              goes_alu;
	logic [DATA_W-1:0] digit_val;
	logic [DATA_W-1:0] cur_top;
	logic [ADDR_W-1:0] a_idx;
	logic [DATA_W-1:0] alu_res;

	// Result of a character that finishes in the decode cycle.
	logic [2:0]        imm_status;
	logic [DATA_W-1:0] imm_top;
	logic [CNT_W-1:0]  imm_count;
	logic              imm_done;
	logic              imm_push;

	assign out_free  = !out_valid_q || !out_stall;
	// A new result beat is loaded when a character finishes this cycle.
	assign out_load  = out_free &&
	                   (((state_q == S_DECODE) && !goes_alu) || (state_q == S_WRITE));

	assign is_digit  = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
	assign is_op     = (char_q == CH_PLUS) || (char_q == CH_MINUS) ||
	                   (char_q == CH_STAR) || (char_q == CH_SLASH);
	assign is_div    = (char_q == CH_SLASH);
	assign is_eq     = (char_q == CH_EQUAL);
	assign full      = (count_q >= DEPTH_CNT);
	assign has_two   = (count_q >= CNT_W'(2));
	assign goes_alu  = is_op && has_two && !(is_div && (top_q == '0));
	// Digits share their low nibble with their value.
	assign digit_val = DATA_W'(char_q[3:0]);
	assign cur_top   = (count_q != '0) ? top_q : '0;
	// Operand a sits just below the top; the result is written back there.
	assign a_idx     = ADDR_W'(count_q - CNT_W'(2));

	always_comb begin
		imm_status = STAT_INVALID;
		imm_top    = cur_top;
		imm_count  = count_q;
		imm_done   = 1'b0;
		imm_push   = 1'b0;
		if (is_digit) begin
			if (full) begin
				imm_status = STAT_OVERFLOW;
			end else begin
				imm_status = STAT_OK;
				imm_push   = 1'b1;
				imm_top    = digit_val;
				imm_count  = count_q + CNT_W'(1);
			end
		end else if (is_op) begin
			// Only the rejected cases end here: too few entries or a zero divisor.
			imm_status = has_two ? STAT_DIVZERO : STAT_UNDERFLOW;
		end else if (is_eq) begin
			if (count_q == '0) begin
				imm_status = STAT_UNDERFLOW;
				imm_top    = '0;
			end else begin
				imm_status = STAT_OK;
				imm_top    = top_q;
				imm_count  = '0;
				imm_done   = 1'b1;
			end
		end
	end

	// Operand a comes from memory, operand b from the top copy.
	always_comb begin
		case (char_q)
			CH_PLUS:  alu_res = ram_rd + top_q;
			CH_MINUS: alu_res = ram_rd - top_q;
			CH_STAR:  alu_res = ram_rd * top_q;
			default:  alu_res = '0;
		endcase
	end

	// Memory accesses. A read and a write never meet on one entry in the
	// same cycle, since each character runs alone through the sequencer.
	always_comb begin
		ram_req = '0;
		case (state_q)
			S_DECODE: begin
				if (is_digit && !full && out_free) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = ADDR_W'(count_q);
					ram_req.wdata = digit_val;
				end
				if (goes_alu) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = a_idx;
				end
			end
			S_WRITE: begin
				if (out_free) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = a_idx;
					ram_req.wdata = res_q;
				end
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	assign div_req.start    = (state_q == S_READ_A) && is_div;
	assign div_req.dividend = ram_rd;
	assign div_req.divisor  = top_q;

	rpn_stack_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (ram_rd)
	);

	rpn_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			top_q       <= '0;
			res_q       <= '0;
			status_q    <= STAT_OK;
			top_value_q <= '0;
			depth_q     <= '0;
			done_res_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						char_q  <= char_code;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (goes_alu) begin
						state_q <= S_READ_A;
					end else if (out_free) begin
						count_q     <= imm_count;
						if (imm_push) begin
							top_q <= digit_val;
						end
						status_q    <= imm_status;
						top_value_q <= imm_top;
						depth_q     <= 6'(imm_count);
						done_res_q  <= imm_done;
						state_q     <= S_IDLE;
					end
				end
				S_READ_A: begin
					if (is_div) begin
						state_q <= S_DIV_WAIT;
					end else begin
						res_q   <= alu_res;
						state_q <= S_WRITE;
					end
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						res_q   <= div_rsp.quotient;
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (out_free) begin
						top_q       <= res_q;
						count_q     <= count_q - CNT_W'(1);
						status_q    <= STAT_OK;
						top_value_q <= res_q;
						depth_q     <= 6'(count_q - CNT_W'(1));
						done_res_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign top_value = top_value_q;
	assign depth     = depth_q;
	assign done_res  = done_res_q;

endmodule

// ----- src/rpn_stack_ram.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_ram: operand stack storage
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rpn_stack_ram
	import rpn_pkg::*;
(
	input  logic              clk,
	input  ram_req_t          req,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data_q <= mem_q[req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/rpn_divider.sv -----
// ----------------------------------------------------------------------------
// rpn_divider: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, with the
// sign applied on the way out. The quotient truncates toward zero.
// ----------------------------------------------------------------------------
module rpn_divider
	import rpn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic                  fin_q;
	logic                  neg_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [DATA_W-1:0]     rem_q;
	logic [DATA_W-1:0]     quo_q;
	logic [DATA_W-1:0]     dvs_q;

	logic                  a_neg;
	logic                  b_neg;
	logic [DATA_W-1:0]     mag_a;
	logic [DATA_W-1:0]     mag_b;
	logic [DATA_W:0]       shifted;
	logic [DATA_W+1:0]     trial;

	assign a_neg   = req.dividend[DATA_W-1];
	assign b_neg   = req.divisor[DATA_W-1];
	assign mag_a   = a_neg ? (~req.dividend + DATA_W'(1)) : req.dividend;
	assign mag_b   = b_neg ? (~req.divisor + DATA_W'(1)) : req.divisor;

	// Shift the next dividend bit into the partial remainder and try the subtract.
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			step_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DIV_STEP_W'(1);
				if (step_q == DIV_STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= a_neg ^ b_neg;
		end else if (busy_q) begin
			if (!trial[DATA_W+1]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = fin_q;
	assign rsp.quotient = neg_q ? (~quo_q + DATA_W'(1)) : quo_q;

endmodule

// ----- src/rpn_checker.sv -----
// ----------------------------------------------------------------------------
// rpn_checker: port-level checks for the RPN stack calculator
// Watches the top-level ports and is attached to the core by a bind.
// ----------------------------------------------------------------------------
module rpn_checker
	import rpn_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [31:0] top_value,
	input logic [5:0]  depth,
	input logic        done_res
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// A finished expression leaves an empty stack and reports success.
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> (depth == 6'd0) && (status == STAT_OK))
		else $error("done beat with nonempty stack or error status");

	// An error never marks an answer.
	a_err_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_OK) |-> !done_res)
		else $error("error beat carries done");

	// A rejected division leaves the zero divisor on top.
	a_divzero_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_DIVZERO) |-> (top_value == 32'd0) &&
		(depth >= 6'd2))
		else $error("divide by zero beat with wrong top or depth");

	// A taken character keeps the input stalled while it is worked on.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input beat taken while a character is in progress");

endmodule

bind rpn_stack_calculator_core rpn_checker u_rpn_checker (.*);

// ----- bench/rpn_stack_calculator_core_tb.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core_tb: self-checking bench for the RPN calculator core
// Streams characters into the core and predicts every report beat on its own
// copy of the stack. Each report is compared field by field in arrival order.
// Runs go through three traffic phases: a slow receiver, then a slow sender,
// then no idling at all.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core_tb
	import rpn_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// A divide is the slowest character. The watchdog allows far more than a
	// divide plus long random stall runs before it gives up.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 80;
	localparam int PHASE_CHARS    = 300;

	typedef enum logic {
		ENTRY_CHAR,
		ENTRY_DRAIN
	} entry_kind_t;

	// One entry of the stimulus list: a character to send, or a marker that
	// makes the sender hold off until every report has come back, after which
	// the traffic phase changes.
	typedef struct {
		entry_kind_t kind;
		logic [7:0]  ch;
		int          phase;
	} stim_entry_t;

	// One report beat as the core should present it.
	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] top;
		logic [5:0]         depth;
		logic               done;
	} calc_report_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [7:0]         char_code  = 8'h00;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] top_value;
	logic [5:0]         depth;
	logic               done_res;

	// Set at each rising edge when the input beat of that edge was taken, so
	// that the driver knows at the next falling edge whether to move on.
	logic in_taken = 1'b0;

	stim_entry_t  char_queue[$];
	calc_report_t pending_reports[$];

	// The bench's own stack and entry count.
	logic [31:0] model_stack [DEPTH];
	int          model_count = 0;

	int cur_phase     = 0;
	int chars_queued  = 0;
	int chars_taken   = 0;
	int answers_seen  = 0;
	int error_reports = 0;
	int mismatches    = 0;
	int idle_cycles   = 0;

	rpn_stack_calculator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.top_value (top_value),
		.depth     (depth),
		.done_res  (done_res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Idle percentage per phase. The first phase backs up the core's output,
	// the second starves it of input, and the last runs at full speed.
	function automatic int idle_pct(input int ph, input bit receiver);
		case (ph)
			0:       return receiver ? 79 : 33;
			1:       return receiver ? 33 : 79;
			default: return 0;
		endcase
	endfunction

	// Applies one character to the bench's stack and returns the report the
	// core must give for it. Every error leaves the stack as it was.
	function automatic calc_report_t evaluate_char(input logic [7:0] ch);
		calc_report_t rep;
		logic [31:0]  a;
		logic [31:0]  b;
		logic [31:0]  r;
		logic [31:0]  mag_a;
		logic [31:0]  mag_b;
		logic [31:0]  quot;
		rep        = '0;
		rep.status = STAT_OK;
		r          = '0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			// A push onto a full stack is an overflow.
			if (model_count >= DEPTH) begin
				rep.status = STAT_OVERFLOW;
			end else begin
				model_stack[model_count] = {24'd0, ch - CH_ZERO};
				model_count++;
			end
		end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH) begin
			if (model_count < 2) begin
				rep.status = STAT_UNDERFLOW;
			end else begin
				b = model_stack[model_count - 1];
				a = model_stack[model_count - 2];
				case (ch)
					CH_PLUS:  r = a + b;
					CH_MINUS: r = a - b;
					CH_STAR:  r = a * b;
					default: begin
						if (b == 32'd0) begin
							rep.status = STAT_DIVZERO;
						end else begin
							// Divide magnitudes and fix the sign afterwards. This
							// truncates toward zero, and the most negative value
							// over minus one wraps back to itself.
							mag_a = a[31] ? (32'd0 - a) : a;
							mag_b = b[31] ? (32'd0 - b) : b;
							quot  = mag_a / mag_b;
							r     = (a[31] != b[31]) ? (32'd0 - quot) : quot;
						end
					end
				endcase
				if (rep.status == STAT_OK) begin
					model_stack[model_count - 2] = r;
					model_count--;
				end
			end
		end else if (ch == CH_EQUAL) begin
			// The answer is popped and the whole stack is dropped.
			if (model_count == 0) begin
				rep.status = STAT_UNDERFLOW;
			end else begin
				rep.top     = model_stack[model_count - 1];
				rep.done    = 1'b1;
				model_count = 0;
			end
		end else begin
			rep.status = STAT_INVALID;
		end
		if (!rep.done && model_count > 0) begin
			rep.top = model_stack[model_count - 1];
		end
		rep.depth = 6'(model_count);
		return rep;
	endfunction

	task automatic add_char(input logic [7:0] ch, input int phase);
		stim_entry_t ent;
		ent.kind  = ENTRY_CHAR;
		ent.ch    = ch;
		ent.phase = phase;
		char_queue.push_back(ent);
		chars_queued++;
	endtask

	task automatic add_drain(input int next_phase);
		stim_entry_t ent;
		ent.kind  = ENTRY_DRAIN;
		ent.ch    = 8'h00;
		ent.phase = next_phase;
		char_queue.push_back(ent);
	endtask

	function automatic logic [7:0] random_op();
		case ($urandom_range(3))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	function automatic logic [7:0] random_digit();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	// Pushes past the top of the stack, folds a few entries and finishes.
	task automatic add_fill(input int phase);
		int extra;
		extra = $urandom_range(1, 3);
		for (int i = 0; i < DEPTH + extra; i++) begin
			add_char(random_digit(), phase);
		end
		for (int i = 0; i < $urandom_range(1, 4); i++) begin
			add_char(random_op(), phase);
		end
		add_char(CH_EQUAL, phase);
	endtask

	// Builds two to the 31st, which wraps to the most negative value, then
	// divides it by minus one. The tail walks over the other wrap points.
	task automatic add_wrap_chain(input int phase);
		add_char(CH_ZERO + 8'd2, phase);
		for (int i = 0; i < 10; i++) begin
			add_char(CH_ZERO + 8'd8, phase);
			add_char(CH_STAR, phase);
		end
		add_char(CH_ZERO, phase);
		add_char(CH_ZERO + 8'd1, phase);
		add_char(CH_MINUS, phase);
		add_char(CH_SLASH, phase);
		if ($urandom_range(1)) begin
			add_char(CH_ZERO + 8'd1, phase);
			add_char(CH_MINUS, phase);
			add_char(CH_NINE, phase);
			add_char(CH_PLUS, phase);
		end
		add_char(CH_EQUAL, phase);
	endtask

	// One random sequence. Most are well-formed expressions with random
	// digits and operators; the rest are broken fragments, raw noise, full-stack runs and wrap chains.
	task automatic add_random_sequence(input int phase);
		int pick;
		int operands;
		int live;
		int pushed;
		pick = $urandom_range(99);
		if (pick < 70) begin
			operands = $urandom_range(1, 8);
			live     = 0;
			pushed   = 0;
			while (pushed < operands || live > 1) begin
				if (pushed < operands && (live < 2 || $urandom_range(1) == 0)) begin
					add_char(random_digit(), phase);
					pushed++;
					live++;
				end else begin
					add_char(random_op(), phase);
					live--;
				end
			end
			add_char(CH_EQUAL, phase);
		end else if (pick < 82) begin
			for (int i = 0; i < $urandom_range(1, 6); i++) begin
				case ($urandom_range(3))
					0:       add_char(random_digit(), phase);
					1:       add_char(random_op(), phase);
					2:       add_char(CH_EQUAL, phase);
					default: add_char(8'($urandom_range(255)), phase);
				endcase
			end
		end else if (pick < 94) begin
			for (int i = 0; i < $urandom_range(1, 3); i++) begin
				add_char(8'($urandom_range(255)), phase);
			end
		end else if (pick < 97) begin
			add_fill(phase);
		end else begin
			add_wrap_chain(phase);
		end
	endtask

	// Driver: moves to the next character at the falling edge once the
	// current beat was taken, and drives the receiver's stall at random.
	always @(negedge clk) begin : drive_proc
		logic        next_valid;
		logic [7:0]  next_char;
		stim_entry_t ent;
		if (arst_n) begin
			next_valid = in_valid;
			next_char  = char_code;
			if (!in_valid || in_taken) begin
				next_valid = 1'b0;
				// A drain marker holds the sender until the core has answered
				// everything; then the next traffic phase begins.
				if (char_queue.size() > 0 && char_queue[0].kind == ENTRY_DRAIN &&
						pending_reports.size() == 0) begin
					cur_phase = char_queue[0].phase;
					void'(char_queue.pop_front());
				end
				if (char_queue.size() > 0 && char_queue[0].kind == ENTRY_CHAR &&
						$urandom_range(99) >= idle_pct(cur_phase, 1'b0)) begin
					ent        = char_queue.pop_front();
					next_valid = 1'b1;
					next_char  = ent.ch;
				end
			end
			in_valid  <= next_valid;
			char_code <= next_char;
			out_stall <= ($urandom_range(99) < idle_pct(cur_phase, 1'b1));
		end
	end

	// Monitor: checks a report beat against the oldest prediction first, so
	// that a character taken at the same edge can never cover a stray report,
	// then predicts the report for any character taken at this edge.
	always @(posedge clk) begin : check_proc
		calc_report_t want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (done_res) begin
					answers_seen++;
				end
				if (status != STAT_OK) begin
					error_reports++;
				end
				if (pending_reports.size() == 0) begin
					$error("report beat with no character pending: status %0d top_value %0d",
						status, top_value);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (top_value !== want.top) begin
						$error("top_value: expected %0d, got %0d", want.top, top_value);
						mismatches++;
					end
					if (depth !== want.depth) begin
						$error("depth: expected %0d, got %0d", want.depth, depth);
						mismatches++;
					end
					if (done_res !== want.done) begin
						$error("done_res: expected %0d, got %0d", want.done, done_res);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				pending_reports.push_back(evaluate_char(char_code));
				chars_taken++;
			end
		end
	end

	// Watchdog: a long stretch with no beat on either channel means the core
	// has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired after %0d cycles without a beat", idle_cycles);
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		// Directed opening: errors on an empty stack, the edges of the
		// character ranges, divide by zero, and truncation toward zero.
		add_char(CH_EQUAL, 0);
		add_char(CH_PLUS, 0);
		add_char(CH_ZERO + 8'd5, 0);
		add_char(CH_STAR, 0);
		add_char(8'h00, 0);
		add_char(8'hFF, 0);
		add_char(8'h80, 0);
		add_char(CH_NINE + 8'd1, 0);
		add_char(CH_ZERO - 8'd2, 0);
		add_char(CH_PLUS + 8'd1, 0);
		add_char(CH_NINE, 0);
		add_char(CH_PLUS, 0);
		add_char(CH_ZERO + 8'd3, 0);
		add_char(CH_MINUS, 0);
		add_char(CH_ZERO, 0);
		add_char(CH_SLASH, 0);
		add_char(CH_PLUS, 0);
		add_char(CH_ZERO + 8'd7, 0);
		add_char(CH_SLASH, 0);
		add_char(CH_ZERO + 8'd4, 0);
		add_char(CH_MINUS, 0);
		add_char(CH_ZERO + 8'd2, 0);
		add_char(CH_SLASH, 0);
		add_char(CH_EQUAL, 0);

		// Each phase opens with the wrap chain and a full-stack run, then
		// fills up with random sequences.
		for (int ph = 0; ph < 3; ph++) begin
			if (ph > 0) begin
				add_drain(ph);
			end
			add_wrap_chain(ph);
			add_fill(ph);
			while (chars_queued < PHASE_CHARS * (ph + 1)) begin
				add_random_sequence(ph);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (char_queue.size() != 0 || in_valid || pending_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_reports.size() != 0) begin
			$error("%0d reports never arrived", pending_reports.size());
			mismatches++;
		end

		$display("Sent %0d characters over three traffic phases; %0d answers returned.",
			chars_taken, answers_seen);
		$display("Error reports seen: %0d (invalid, underflow, overflow, divide by zero).",
			error_reports);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
